/* design/kts_pkg.sv */
// shared constants, codes and controller/datapath interface types
// for the keyed table search block; no dependencies
package kts_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 256;
  localparam int KEY_WIDTH   = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int POS_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  // input actions
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SEARCH = 1'b1;

  // search modes
  localparam logic [1:0] MODE_UNORDERED = 2'd0;
  localparam logic [1:0] MODE_ORDERED   = 2'd1;
  localparam logic [1:0] MODE_BINARY    = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE = 2'd1;

  // result source select
  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_PEND = 2'd1;
  localparam logic [1:0] RES_MID  = 2'd2;

  typedef struct packed {
    logic       mem_write;   // store the input key at the input position
    logic       load;        // capture key and bounds for a new search
    logic       scan_issue;  // read at the scan pointer and step it down
    logic       bin_issue;   // read at the midpoint of the window
    logic       bin_lower;   // move the upper bound below the midpoint
    logic       bin_raise;   // move the lower bound above the midpoint
    logic       finish;      // present a result for one cycle
    logic [1:0] res_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       count_zero;  // no positions in use
    logic [1:0] mode;
    logic       scan_more;   // scan pointer not yet at zero
    logic       pend_valid;  // registered read data belongs to a scan read
    logic       eq;          // sought key equals read key
    logic       lt;          // sought key below read key
    logic       bin_empty;   // binary window is empty
  } dp_status_t;

endpackage

/* design/keyed_table_search.sv */
// Keyed table search. A transaction with action 0 stores search_key at
// position entry_index (1..256) and gives no result; out-of-range
// positions are ignored. A transaction with action 1 searches positions 1 to
// entry_count and, when finished, shows found_index (0 when not found) with
// done high for exactly one cycle; the receiver cannot stall, so capture it
// then. The key memory has one registered read port: sequential modes 0 and
// 1 read one entry per cycle, and binary mode reads and then compares for
// each probe. A count of zero or mode 3 answers 0 in the cycle after the
// start. busy is high while a search runs.
// Configuration writes are accepted at any time but must be made while idle.
// top level, depends on kts_pkg, kts_ctrl and kts_datapath
module keyed_table_search (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           action,
  input  logic [kts_pkg::POS_W-1:0]      entry_index,
  input  logic [31:0]                    search_key,
  output logic [kts_pkg::POS_W-1:0]      found_index,
  output logic                           done,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [kts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kts_pkg::CFG_DATA_W-1:0] cfg_data
);
  import kts_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  // controller
  kts_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath
  kts_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .entry_index (entry_index),
    .search_key  (search_key),
    .cmd         (cmd),
    .status      (status),
    .found_index (found_index),
    .done        (done)
  );

endmodule

/* design/kts_ctrl.sv */
// controller state machine for the keyed table search block
// depends on kts_pkg; drives the datapath through ctrl_cmd_t
module kts_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               action,
  input  kts_pkg::dp_status_t status,
  output kts_pkg::ctrl_cmd_t  cmd,
  output logic               busy
);
  import kts_pkg::*;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SCAN    = 2'd1;
  localparam logic [1:0] ST_BIN_RD  = 2'd2;
  localparam logic [1:0] ST_BIN_CMP = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       scan_hit;

  assign busy = (state != ST_IDLE);

  // ordered scan stops at the first key not above the sought one
  assign scan_hit = (status.mode == MODE_UNORDERED) ? status.eq : !status.lt;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_sel = RES_ZERO;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (action == ACT_WRITE) begin
            cmd.mem_write = 1'b1;
          end else begin
            cmd.load = 1'b1;
            if (status.count_zero || !(status.mode inside
                {MODE_UNORDERED, MODE_ORDERED, MODE_BINARY})) begin
              cmd.finish = 1'b1;
            end else if (status.mode == MODE_BINARY) begin
              state_next = ST_BIN_RD;
            end else begin
              state_next = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        if (status.pend_valid && scan_hit) begin
          cmd.finish  = 1'b1;
          cmd.res_sel = status.eq ? RES_PEND : RES_ZERO;
          state_next  = ST_IDLE;
        end else if (!status.scan_more) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.scan_issue = 1'b1;
        end
      end
      ST_BIN_RD: begin
        if (status.bin_empty) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.bin_issue = 1'b1;
          state_next    = ST_BIN_CMP;
        end
      end
      ST_BIN_CMP: begin
        if (status.eq) begin
          cmd.finish  = 1'b1;
          cmd.res_sel = RES_MID;
          state_next  = ST_IDLE;
        end else begin
          cmd.bin_lower = status.lt;
          cmd.bin_raise = !status.lt;
          state_next    = ST_BIN_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/kts_datapath.sv */
// datapath of the keyed table search block: configuration registers,
// key memory, search pointers, compare and result register; depends on kts_pkg
module kts_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [kts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [kts_pkg::POS_W-1:0]      entry_index,
  input  logic [31:0]                    search_key,
  input  kts_pkg::ctrl_cmd_t             cmd,
  output kts_pkg::dp_status_t            status,
  output logic [kts_pkg::POS_W-1:0]      found_index,
  output logic                           done
);
  import kts_pkg::*;

  logic [KEY_WIDTH-1:0] key_mem [TABLE_DEPTH];

  logic [POS_W-1:0]     entry_count;
  logic [1:0]           search_mode;
  logic [POS_W-1:0]     count_eff;
  logic [KEY_WIDTH-1:0] key;
  logic [KEY_WIDTH-1:0] rdata;
  logic [POS_W-1:0]     scan_pos;
  logic [POS_W-1:0]     pend_pos;
  logic                 pend_valid;
  logic [POS_W-1:0]     low;
  logic [POS_W-1:0]     high;
  logic [POS_W-1:0]     mid;
  logic [POS_W-1:0]     mid_q;
  logic [POS_W:0]       mid_sum;
  logic                 rd_en;
  logic [ADDR_W-1:0]    rd_addr;
  logic [ADDR_W-1:0]    wr_addr;
  logic                 wr_ok;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      search_mode <= MODE_UNORDERED;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENTRY_COUNT: entry_count <= cfg_data;
        REG_SEARCH_MODE: search_mode <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // count clamped to the table depth
  assign count_eff = (entry_count > POS_W'(TABLE_DEPTH)) ? POS_W'(TABLE_DEPTH)
                                                         : entry_count;

  // binary midpoint, both bounds non-negative
  assign mid_sum = {1'b0, low} + {1'b0, high};
  assign mid     = mid_sum[POS_W:1];

  // memory addressing, positions are one-based
  assign wr_ok   = (entry_index != '0) && (entry_index <= POS_W'(TABLE_DEPTH));
  assign wr_addr = ADDR_W'(entry_index - POS_W'(1));
  assign rd_en   = cmd.scan_issue || cmd.bin_issue;
  assign rd_addr = cmd.bin_issue ? ADDR_W'(mid - POS_W'(1))
                                 : ADDR_W'(scan_pos - POS_W'(1));

  // key memory, registered read
  always_ff @(posedge clk) begin
    if (cmd.mem_write && wr_ok) begin
      key_mem[wr_addr] <= search_key[KEY_WIDTH-1:0];
    end
    if (rd_en) begin
      rdata <= key_mem[rd_addr];
    end
  end

  // search pointers and bounds
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key      <= search_key[KEY_WIDTH-1:0];
      scan_pos <= count_eff;
      low      <= POS_W'(1);
      high     <= count_eff;
    end
    if (cmd.scan_issue) begin
      scan_pos <= scan_pos - POS_W'(1);
      pend_pos <= scan_pos;
    end
    if (cmd.bin_issue) begin
      mid_q <= mid;
    end
    if (cmd.bin_lower) begin
      high <= mid_q - POS_W'(1);
    end
    if (cmd.bin_raise) begin
      low <= mid_q + POS_W'(1);
    end
  end

  // pending scan read flag
  always_ff @(posedge clk) begin
    if (rst || cmd.load) begin
      pend_valid <= 1'b0;
    end else if (cmd.scan_issue) begin
      pend_valid <= 1'b1;
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      case (cmd.res_sel)
        RES_PEND: found_index <= pend_pos;
        RES_MID:  found_index <= mid_q;
        default:  found_index <= '0;
      endcase
    end
  end

  // status to the controller
  always_comb begin
    status.count_zero = (count_eff == '0);
    status.mode       = search_mode;
    status.scan_more  = (scan_pos != '0);
    status.pend_valid = pend_valid;
    status.eq         = (key == rdata);
    status.lt         = (key < rdata);
    status.bin_empty  = (low > high);
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// testbench for keyed_table_search: random and directed writes and searches,
// results checked against a cycle-free model of the table; depends on kts_pkg
module tb;
  import kts_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;  // no search, always answers zero
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic                   action;
    logic [POS_W-1:0]       pos;
    logic [31:0]            key;
  } table_op_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  action = ACT_WRITE;
  logic [POS_W-1:0]      entry_index = '0;
  logic [31:0]           search_key = '0;
  logic [POS_W-1:0]      found_index;
  logic                  done;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // model state, updated on accepted transactions
  logic [31:0]           stored_keys [1:TABLE_DEPTH];
  logic [CFG_DATA_W-1:0] pred_count = '0;
  logic [1:0]            pred_mode = MODE_UNORDERED;
  logic [POS_W-1:0]      found_expect_q [$];

  // generator view of the table, ahead of the model
  logic [31:0]           planned_keys [1:TABLE_DEPTH];
  int                    plan_count = 0;

  table_op_t             pending_ops [$];
  table_op_t             cur_op;
  int                    sender_idle_pct = 21;
  int                    error_count = 0;

  keyed_table_search i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .action      (action),
    .entry_index (entry_index),
    .search_key  (search_key),
    .found_index (found_index),
    .done        (done),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #1 clk = ~clk;

  // position that the block should answer for a search
  function automatic logic [POS_W-1:0] lookup_position(logic [31:0] key);
    int n;
    int i;
    int lo;
    int hi;
    int mid;
    int found;
    n = (pred_count > TABLE_DEPTH) ? TABLE_DEPTH : pred_count;
    found = 0;
    case (pred_mode)
      MODE_UNORDERED: begin
        for (i = n; i > 0 && found == 0; i--)
          if (stored_keys[i] == key) found = i;
      end
      MODE_ORDERED: begin
        i = n;
        while (i > 0 && key < stored_keys[i]) i--;
        if (i > 0 && stored_keys[i] == key) found = i;
      end
      MODE_BINARY: begin
        lo = 1;
        hi = n;
        while (lo <= hi && found == 0) begin
          mid = lo + (hi - lo) / 2;
          if (key == stored_keys[mid]) found = mid;
          else if (key < stored_keys[mid]) hi = mid - 1;
          else lo = mid + 1;
        end
      end
      default: found = 0;
    endcase
    return found[POS_W-1:0];
  endfunction

  // driver: applies the model on acceptance, then offers the next transaction
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        if (cur_op.action == ACT_WRITE) begin
          if (cur_op.pos >= 1 && cur_op.pos <= TABLE_DEPTH)
            stored_keys[cur_op.pos] = cur_op.key;
        end else begin
          found_expect_q.push_back(lookup_position(cur_op.key));
        end
      end
      if (!start || !busy) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          cur_op = pending_ops.pop_front();
          action <= cur_op.action;
          entry_index <= cur_op.pos;
          search_key <= cur_op.key;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // register writes seen by the model
  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ENTRY_COUNT) pred_count <= cfg_data;
      else if (cfg_index == REG_SEARCH_MODE) pred_mode <= cfg_data[1:0];
    end
  end

  // monitor: each result against the oldest expectation
  always @(posedge clk) begin
    logic [POS_W-1:0] want;
    if (!rst && done) begin
      if (found_expect_q.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result: found_index %0d with no search pending", found_index);
      end else begin
        want = found_expect_q.pop_front();
        if (found_index !== want) begin
          error_count++;
          if (error_count <= 10)
            $display("found_index mismatch: expected %0d, got %0d", want, found_index);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[CFG_DATA_W-1:0];
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_ENTRY_COUNT) plan_count = data;
    @(negedge clk);
  endtask

  // wait until the block is idle and every search has answered
  task automatic settle();
    @(negedge clk);
    while (pending_ops.size() != 0 || start || busy || found_expect_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic void queue_write(int pos, logic [31:0] key);
    table_op_t op;
    op.action = ACT_WRITE;
    op.pos = pos[POS_W-1:0];
    op.key = key;
    if (pos >= 1 && pos <= TABLE_DEPTH) planned_keys[pos] = key;
    pending_ops.push_back(op);
  endfunction

  function automatic void queue_search(logic [31:0] key);
    table_op_t op;
    op.action = ACT_SEARCH;
    op.pos = POS_W'($urandom_range(0, 511));
    op.key = key;
    pending_ops.push_back(op);
  endfunction

  // whole table rewritten ascending, with some repeated keys
  function automatic void queue_ascending_fill();
    longint unsigned base;
    int p;
    base = 0;
    for (p = 1; p <= TABLE_DEPTH; p++) begin
      queue_write(p, base[31:0]);
      if ($urandom_range(9) != 0) base += $urandom_range(1, 16_700_000);
    end
  endfunction

  function automatic void queue_random_items(int count);
    int k;
    int n;
    int p;
    int roll;
    longint unsigned lo;
    longint unsigned hi;
    logic [31:0] key;
    n = (plan_count > TABLE_DEPTH) ? TABLE_DEPTH : plan_count;
    for (k = 0; k < count; k++) begin
      roll = $urandom_range(99);
      if (roll < 25) begin
        // writes: mostly keeping the order, some breaking it, some ignored
        p = $urandom_range(1, TABLE_DEPTH);
        roll = $urandom_range(99);
        if (roll < 70) begin
          lo = (p > 1) ? planned_keys[p - 1] : 0;
          hi = (p < TABLE_DEPTH) ? planned_keys[p + 1] : 64'hFFFF_FFFF;
          if (lo <= hi) key = 32'(lo + ({$urandom} % (hi - lo + 1)));
          else key = $urandom;
          queue_write(p, key);
        end else if (roll < 85) begin
          queue_write(p, $urandom);
        end else begin
          queue_write(($urandom_range(1) == 0) ? 0 : $urandom_range(TABLE_DEPTH + 1, 511),
                      $urandom);
        end
      end else begin
        // searches: hits, near misses and arbitrary keys
        roll = $urandom_range(99);
        if (n > 0 && roll < 55) begin
          key = planned_keys[$urandom_range(1, n)];
        end else if (n > 0 && roll < 80) begin
          key = planned_keys[$urandom_range(1, n)];
          key = ($urandom_range(1) == 0) ? key + 1 : key - 1;
        end else if (roll < 85) begin
          key = ($urandom_range(1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
        end else begin
          key = $urandom;
        end
        queue_search(key);
      end
    end
  endfunction

  function automatic int pick_count();
    case ($urandom_range(9))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return TABLE_DEPTH;
      4: return 511;
      5: return TABLE_DEPTH + 1;
      default: return $urandom_range(3, TABLE_DEPTH - 1);
    endcase
  endfunction

  // main sequence
  initial begin
    int phase;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_ENTRY_COUNT, 0);
    write_reg(REG_SEARCH_MODE, MODE_UNORDERED);

    // every position written before any search reads it
    queue_ascending_fill();
    settle();

    // directed: empty range, ignored positions, extreme keys, every mode
    queue_search(32'h0);
    queue_write(0, 32'h5);
    queue_write(511, 32'h6);
    queue_write(TABLE_DEPTH + 1, 32'h7);
    queue_write(TABLE_DEPTH, 32'hFFFF_FFFF);
    queue_write(1, 32'h0);
    settle();
    write_reg(REG_ENTRY_COUNT, TABLE_DEPTH);
    queue_search(32'h5);
    queue_search(32'h6);
    queue_search(32'h7);
    queue_search(32'hFFFF_FFFF);
    queue_search(32'h0);
    settle();
    write_reg(REG_ENTRY_COUNT, 511);
    write_reg(REG_SEARCH_MODE, MODE_ORDERED);
    queue_search(32'hFFFF_FFFF);
    queue_search(32'h0);
    queue_search(planned_keys[128]);
    queue_search(planned_keys[128] + 1);
    settle();
    write_reg(REG_ENTRY_COUNT, TABLE_DEPTH);
    write_reg(REG_SEARCH_MODE, MODE_BINARY);
    queue_search(32'h0);
    queue_search(32'hFFFF_FFFF);
    queue_search(planned_keys[77]);
    queue_search(planned_keys[77] + 1);
    settle();
    write_reg(REG_SEARCH_MODE, MODE_NONE);
    queue_search(planned_keys[10]);
    settle();
    write_reg(REG_ENTRY_COUNT, 1);
    write_reg(REG_SEARCH_MODE, MODE_BINARY);
    queue_search(32'h0);
    queue_search(32'h1);
    settle();

    // random phases, each with its own setting; the sender behaviour changes every four phases
    for (phase = 0; phase < 12; phase++) begin
      if (phase == 6) begin
        queue_ascending_fill();
        settle();
      end
      sender_idle_pct = (phase < 4) ? 21 : (phase < 8) ? 78 : 0;
      write_reg(REG_ENTRY_COUNT, pick_count());
      write_reg(REG_SEARCH_MODE,
                ($urandom_range(9) == 0) ? MODE_NONE : $urandom_range(0, 2));
      queue_random_items(64);
      settle();
    end

    if (error_count == 0 && found_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

/* filelist.f */
design/kts_pkg.sv
design/kts_ctrl.sv
design/kts_datapath.sv
design/keyed_table_search.sv
test/tb.sv
